// File: hw/rtl/kcbs_pkg.sv
// ----------------------------------------------------------------------------
// K-mer counter package
// Beat types, command and operation codes shared by the k-mer counter blocks.
// ----------------------------------------------------------------------------
package kcbs_pkg;

   // Width of the k-mer length register and of the fill counter.
   localparam int KLEN_W = 4;

   // Width of the packed query k-mer carried on the request channel.
   localparam int QUERY_W = 16;

   // Width of the count field on the response channel.
   localparam int COUNT_OUT_W = 32;

   // Reset value of the k-mer length register.
   localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd6;

   // Depth of the operation queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   // Request commands.
   localparam logic [1:0] CMD_ADD_BASE = 2'd0;
   localparam logic [1:0] CMD_END_SEQ  = 2'd1;
   localparam logic [1:0] CMD_READ     = 2'd2;

   // Operation kinds handed from front to back.
   localparam logic OP_BUMP = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Request beat.
   typedef struct packed {
      logic [1:0]         command;
      logic [1:0]         base;
      logic [QUERY_W-1:0] query_kmer;
   } kcbs_req_type;

   // Response beat.
   typedef struct packed {
      logic [COUNT_OUT_W-1:0] count;
      logic                   saturated;
   } kcbs_rsp_type;

endpackage

// File: hw/rtl/kmer_count_both_strands.sv
// ----------------------------------------------------------------------------
// K-mer counter over both DNA strands
// Counts every k-mer of a base stream together with its reverse complement
// in a saturating count table and answers count queries.
// ----------------------------------------------------------------------------
// After reset the count table is cleared one entry per cycle, 4^K_MAX entries
// in all (65536 at the default K_MAX of 8); req_stall stays high for that
// time, while the length register may already be written. After that the
// front end takes one request beat per cycle, while the queue is not full,
// into a four-entry operation queue. The count memory has one read and one
// write port, so the back end makes its k-mer accesses one at a time: a base
// that completes a window needs two accesses (forward and reverse-complement
// bump), a read one, and end-of-sequence or other beats none. A read's
// operation passes from the queue into the memory stage and then into the
// response register, where the response waits while rsp_stall is high.
module kmer_count_both_strands #(
   parameter int K_MAX       = 8,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  kcbs_pkg::kcbs_req_type       req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output kcbs_pkg::kcbs_rsp_type       rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [kcbs_pkg::KLEN_W-1:0]  csr_data
);
   import kcbs_pkg::*;

   localparam int OP_W = 2 * (2 * K_MAX) + 1;

   logic            clearing;
   logic            op_push, op_full, op_pop, op_empty;
   logic [OP_W-1:0] op_in_data, op_head_data;

   // Front end: windows, length register, classification.
   kcbs_front #(
      .K_MAX(K_MAX)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data),
      .clearing (clearing),
      .op_full  (op_full),
      .op_push  (op_push),
      .op_data  (op_in_data)
   );

   // Operation queue between front and back.
   kcbs_queue #(
      .WIDTH(OP_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (op_push),
      .push_data(op_in_data),
      .full     (op_full),
      .pop      (op_pop),
      .head_data(op_head_data),
      .empty    (op_empty)
   );

   // Back end: count memory and responses.
   kcbs_back #(
      .K_MAX      (K_MAX),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .clearing (clearing),
      .op_empty (op_empty),
      .op_data  (op_head_data),
      .op_pop   (op_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

// File: hw/rtl/kcbs_front.sv
// ----------------------------------------------------------------------------
// K-mer counter front end
// Accepts request beats, keeps the rolling forward and reverse-complement
// windows and the k-mer length register, and queues bump and read operations.
// ----------------------------------------------------------------------------
module kcbs_front #(
   parameter int K_MAX = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  kcbs_pkg::kcbs_req_type       req_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [kcbs_pkg::KLEN_W-1:0]  csr_data,
   input  logic                         clearing,
   input  logic                         op_full,
   output logic                         op_push,
   output logic [2*(2*K_MAX)+1-1:0]     op_data
);
   import kcbs_pkg::*;

   localparam int TW = 2 * K_MAX;

   typedef struct packed {
      logic          kind;
      logic [TW-1:0] addr_f;
      logic [TW-1:0] addr_r;
   } op_type;

   logic [KLEN_W-1:0] klen_ff;
   logic [TW-1:0]     fwd_ff, fwd_in;
   logic [TW-1:0]     rev_ff, rev_in;
   logic [KLEN_W-1:0] fill_ff, fill_in;
   logic [KLEN_W-1:0] k_eff;
   logic [TW-1:0]     wmask;
   logic [TW-1:0]     comp_bits;
   logic [TW-1:0]     fwd_next, rev_next;
   logic [KLEN_W-1:0] fill_cap, fill_next;
   logic [TW+QUERY_W-1:0] query_ext;
   logic              accept;
   logic              window_full;
   op_type            op;

   // The length register is always ready; the user is to write it only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff <= KLEN_RESET;
      end else if (csr_valid) begin
         klen_ff <= csr_data;
      end
   end

   // Clamp the programmed length into 1..K_MAX.
   always_comb begin
      if (klen_ff == '0) begin
         k_eff = KLEN_W'(1);
      end else if (klen_ff > KLEN_W'(K_MAX)) begin
         k_eff = KLEN_W'(K_MAX);
      end else begin
         k_eff = klen_ff;
      end
   end

   // Window mask covers the low 2k bits.
   always_comb begin
      for (int i = 0; i < TW; i++) begin
         wmask[i] = (i < 2 * int'(k_eff));
      end
   end

   // Rolling windows: forward shifts in at the bottom, complement at the top.
   always_comb begin
      comp_bits = TW'(~req_data.base) << (2 * (int'(k_eff) - 1));
      fwd_next  = TW'({fwd_ff, req_data.base}) & wmask;
      rev_next  = ((rev_ff >> 2) | comp_bits) & wmask;
   end

   // Fill count is capped at k, then advanced until the window is full.
   always_comb begin
      fill_cap  = (fill_ff > k_eff) ? k_eff : fill_ff;
      fill_next = (fill_cap < k_eff) ? fill_cap + KLEN_W'(1) : fill_cap;
      window_full = (fill_next == k_eff);
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = clearing || op_full;

   // Next window state per command.
   always_comb begin
      fwd_in  = fwd_ff;
      rev_in  = rev_ff;
      fill_in = fill_ff;
      if (accept) begin
         case (req_data.command)
            CMD_ADD_BASE: begin
               fwd_in  = fwd_next;
               rev_in  = rev_next;
               fill_in = fill_next;
            end
            CMD_END_SEQ: begin
               fwd_in  = '0;
               rev_in  = '0;
               fill_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff  <= '0;
         rev_ff  <= '0;
         fill_ff <= '0;
      end else begin
         fwd_ff  <= fwd_in;
         rev_ff  <= rev_in;
         fill_ff <= fill_in;
      end
   end

   // Query is masked to the table index width, zero-extended when wider.
   assign query_ext = {{TW{1'b0}}, req_data.query_kmer};

   // Classify the beat into a queued operation.
   always_comb begin
      op      = '0;
      op_push = 1'b0;
      if (accept && req_data.command == CMD_ADD_BASE && window_full) begin
         op.kind   = OP_BUMP;
         op.addr_f = fwd_next;
         op.addr_r = rev_next;
         op_push   = 1'b1;
      end else if (accept && req_data.command == CMD_READ) begin
         op.kind   = OP_READ;
         op.addr_f = query_ext[TW-1:0];
         op_push   = 1'b1;
      end
   end

   assign op_data = op;

endmodule

// File: hw/rtl/kcbs_queue.sv
// ----------------------------------------------------------------------------
// K-mer counter operation queue
// Small FIFO that decouples the front end from the count memory back end.
// ----------------------------------------------------------------------------
module kcbs_queue #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]      used_ff;

   assign full      = (used_ff == (PW+1)'(DEPTH));
   assign empty     = (used_ff == '0);
   assign head_data = entry_ff[rd_ptr_ff];

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers wrap at the depth; occupancy tracks push and pop together.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         case ({push, pop})
            2'b10:   used_ff <= used_ff + (PW+1)'(1);
            2'b01:   used_ff <= used_ff - (PW+1)'(1);
            default: used_ff <= used_ff;
         endcase
      end
   end

endmodule

// File: hw/rtl/kcbs_back.sv
// ----------------------------------------------------------------------------
// K-mer counter back end
// Owns the count memory: clears it after reset, runs saturating
// read-modify-write bumps and answers count reads through a response register.
// ----------------------------------------------------------------------------
module kcbs_back #(
   parameter int K_MAX       = 8,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   output logic                     clearing,
   input  logic                     op_empty,
   input  logic [2*(2*K_MAX)+1-1:0] op_data,
   output logic                     op_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output kcbs_pkg::kcbs_rsp_type   rsp_data
);
   import kcbs_pkg::*;

   localparam int TW    = 2 * K_MAX;
   localparam int DEPTH = 1 << TW;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic          kind;
      logic [TW-1:0] addr_f;
      logic [TW-1:0] addr_r;
   } op_type;

   logic [COUNT_WIDTH-1:0] mem [DEPTH];

   op_type                 head;
   logic                   clearing_ff;
   logic [TW-1:0]          clr_addr_ff;
   logic                   phase_ff, phase_in;
   logic                   stage_valid_ff, stage_valid_in;
   logic                   stage_kind_ff;
   logic [TW-1:0]          stage_addr_ff;
   logic [COUNT_WIDTH-1:0] rd_ff;
   logic                   lw_valid_ff;
   logic [TW-1:0]          lw_addr_ff;
   logic [COUNT_WIDTH-1:0] lw_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   kcbs_rsp_type           rsp_data_ff;
   logic                   rsp_free;
   logic                   stage_done;
   logic                   issue;
   logic [TW-1:0]          issue_addr;
   logic [COUNT_WIDTH-1:0] cur_count, inc_count;
   logic                   mem_we;
   logic [TW-1:0]          mem_waddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;

   assign head      = op_data;
   assign clearing  = clearing_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Clearing pass: one entry per cycle after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + TW'(1);
         if (clr_addr_ff == '1) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // The count read at an edge may miss the write made at that same edge.
   assign cur_count = (lw_valid_ff && lw_addr_ff == stage_addr_ff) ? lw_data_ff : rd_ff;
   assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_WIDTH'(1);

   // A bump always completes; a read needs room in the response register.
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign stage_done = stage_valid_ff && (stage_kind_ff == OP_BUMP || rsp_free);

   // One access per cycle when the stage is free; bumps take two, reads one.
   assign issue      = !clearing_ff && !op_empty && (!stage_valid_ff || stage_done);
   assign issue_addr = (head.kind == OP_BUMP && phase_ff) ? head.addr_r : head.addr_f;
   assign op_pop     = issue && (head.kind == OP_READ || phase_ff);

   always_comb begin
      phase_in = phase_ff;
      if (issue && head.kind == OP_BUMP) begin
         phase_in = !phase_ff;
      end
      if (issue) begin
         stage_valid_in = 1'b1;
      end else if (stage_done) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= 1'b0;
         stage_valid_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         stage_kind_ff <= head.kind;
         stage_addr_ff <= issue_addr;
      end
   end

   // Write port: clearing zeros, otherwise the bumped count.
   always_comb begin
      mem_we    = clearing_ff || (stage_valid_ff && stage_kind_ff == OP_BUMP);
      mem_waddr = clearing_ff ? clr_addr_ff : stage_addr_ff;
      mem_wdata = clearing_ff ? '0 : inc_count;
   end

   // Count memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (issue) begin
         rd_ff <= mem[issue_addr];
      end
   end

   // Last bump write, kept for the bypass.
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else if (mem_we) begin
         lw_valid_ff <= !clearing_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lw_addr_ff <= mem_waddr;
         lw_data_ff <= mem_wdata;
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (stage_done && stage_kind_ff == OP_READ) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_done && stage_kind_ff == OP_READ) begin
         rsp_data_ff.count     <= COUNT_OUT_W'(cur_count);
         rsp_data_ff.saturated <= (cur_count == COUNT_MAX);
      end
   end

endmodule

// File: tb/kmer_count_both_strands_test.sv
// ----------------------------------------------------------------------------
// K-mer counter testbench
// Streams bases, end-of-sequence marks and count reads into the both-strand
// k-mer counter under random idling on both channels, predicts every read
// response from its own copy of the windows and the count table, and checks
// each response field by field. The window length is changed between phases,
// out-of-range values and mid-sequence changes included.
// ----------------------------------------------------------------------------
module kmer_count_both_strands_test;
   import kcbs_pkg::*;

   localparam int WINDOW_MAX   = 8;
   localparam int TALLY_DEPTH  = 1 << (2 * WINDOW_MAX);
   localparam logic [COUNT_OUT_W-1:0] TALLY_MAX = '1;
   localparam int IDLE_PCT     = 32;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_BEATS = 1250;

   // Command code with no meaning; the block must ignore it.
   localparam logic [1:0] CMD_NONE = 2'd3;

   // Predicts the count table and the read responses that it yields.
   class kmer_tally_board;
      logic [COUNT_OUT_W-1:0] tally [TALLY_DEPTH];
      logic [QUERY_W-1:0]     fwd;
      logic [QUERY_W-1:0]     rev;
      logic [KLEN_W-1:0]      fill;
      logic [KLEN_W-1:0]      klen;
      kcbs_rsp_type           due [$];
      int                     errors;

      function new();
         foreach (tally[i]) tally[i] = '0;
         fwd = '0;
         rev = '0;
         fill = '0;
         klen = KLEN_RESET;
         errors = 0;
      endfunction

      // Length zero behaves as one, anything above WINDOW_MAX as WINDOW_MAX.
      function int unsigned window_len();
         if (klen == 0) return 1;
         if (klen > WINDOW_MAX) return WINDOW_MAX;
         return klen;
      endfunction

      function void bump(int unsigned idx);
         idx = idx % TALLY_DEPTH;
         if (tally[idx] != TALLY_MAX) tally[idx] = tally[idx] + 1;
      endfunction

      // Advances the model by one accepted request beat.
      function void note_request(kcbs_req_type r);
         int unsigned k;
         int unsigned wmask;
         int unsigned f;
         int unsigned b;
         kcbs_rsp_type exp_rsp;
         k = window_len();
         wmask = (32'd1 << (2 * k)) - 1;
         b = 32'(r.base);
         case (r.command)
            CMD_ADD_BASE: begin
               f = ((32'(fwd) << 2) | b) & wmask;
               fwd = f[QUERY_W-1:0];
               f = ((32'(rev) >> 2) | ((3 - b) << (2 * (k - 1)))) & wmask;
               rev = f[QUERY_W-1:0];
               if (fill > k) fill = KLEN_W'(k);
               if (fill < k) fill = fill + KLEN_W'(1);
               // Both strands count once the window is full.
               if (fill == k) begin
                  bump(fwd);
                  bump(rev);
               end
            end
            CMD_END_SEQ: begin
               fwd = '0;
               rev = '0;
               fill = '0;
            end
            CMD_READ: begin
               exp_rsp.count = tally[r.query_kmer];
               exp_rsp.saturated = (tally[r.query_kmer] == TALLY_MAX);
               due = {due, exp_rsp};
            end
            default: begin
            end
         endcase
      endfunction

      // Compares one accepted response beat with the oldest prediction.
      function void check_response(kcbs_rsp_type got);
         kcbs_rsp_type want;
         if (due.size() == 0) begin
            $display("%0t: unexpected response, count %0d saturated %0b",
                     $time, got.count, got.saturated);
            errors++;
            return;
         end
         want = due.pop_front();
         if (got.count !== want.count) begin
            $display("%0t: count mismatch, expected %0d actual %0d",
                     $time, want.count, got.count);
            errors++;
         end
         if (got.saturated !== want.saturated) begin
            $display("%0t: saturated mismatch, expected %0b actual %0b",
                     $time, want.saturated, got.saturated);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   kcbs_req_type      req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   kcbs_rsp_type      rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [KLEN_W-1:0] csr_data = '0;

   kmer_tally_board board;
   bit              quiet = 1'b0;

   kmer_count_both_strands dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Response side: check each accepted beat, then pick the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
   end

   // Offers one request beat after a random idle stretch and waits for it.
   task automatic push_request(input logic [1:0] cmd, input logic [1:0] b,
                               input logic [QUERY_W-1:0] q);
      kcbs_req_type r;
      r.command = cmd;
      r.base = b;
      r.query_kmer = q;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   // Writes the window length register.
   task automatic write_length(input logic [KLEN_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.klen = v;
   endtask

   // Waits for all reads to answer, then lets queued bumps finish.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (board.due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random beat: mostly bases, else ends, reads mostly of live k-mers or no-ops.
   task automatic push_random(output bit counted);
      int unsigned pick;
      int unsigned src;
      logic [QUERY_W-1:0] q;
      logic [1:0] b;
      pick = $urandom_range(99);
      src = $urandom_range(99);
      b = 2'($urandom_range(3));
      q = QUERY_W'($urandom);
      counted = 1'b1;
      if (pick < 62) begin
         push_request(CMD_ADD_BASE, b, q);
      end else if (pick < 68) begin
         push_request(CMD_END_SEQ, b, q);
      end else if (pick < 95) begin
         if (src < 45) q = board.fwd;
         else if (src < 70) q = board.rev;
         else if (src < 85) q = q & QUERY_W'((32'd1 << (2 * board.window_len())) - 1);
         push_request(CMD_READ, b, q);
      end else begin
         push_request(CMD_NONE, b, q);
         counted = 1'b0;
      end
   endtask

   initial begin
      logic [KLEN_W-1:0] lengths [12];
      int per_phase;
      int n;
      bit counted;
      lengths = '{4'd2, 4'd15, 4'd0, 4'd1, 4'd8, 4'd9, 4'd3, 4'd4, 4'd5, 4'd6,
                  4'd7, 4'd2};
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Short window first: a short sequence, palindromes and ignored commands.
      write_length(lengths[0]);
      push_request(CMD_ADD_BASE, 2'd0, 16'hFFFF);
      push_request(CMD_END_SEQ, 2'd3, 16'hFFFF);
      push_request(CMD_ADD_BASE, 2'd1, 16'h0000);
      push_request(CMD_ADD_BASE, 2'd2, 16'h0000);
      push_request(CMD_ADD_BASE, 2'd3, 16'h0000);
      push_request(CMD_ADD_BASE, 2'd3, 16'hFFFF);
      push_request(CMD_READ, 2'd3, 16'h0006);
      push_request(CMD_READ, 2'd0, 16'h000F);
      push_request(CMD_READ, 2'd3, 16'h0000);
      push_request(CMD_NONE, 2'd3, 16'hFFFF);
      push_request(CMD_READ, 2'd0, 16'hFFFF);
      push_request(CMD_ADD_BASE, 2'd0, 16'h0000);
      push_request(CMD_END_SEQ, 2'd0, 16'h0000);
      push_request(CMD_ADD_BASE, 2'd3, 16'h0000);
      push_request(CMD_ADD_BASE, 2'd3, 16'h0000);
      push_request(CMD_ADD_BASE, 2'd3, 16'h0000);
      push_request(CMD_READ, 2'd1, 16'h000F);
      push_request(CMD_ADD_BASE, 2'd2, 16'h0000);
      push_request(CMD_ADD_BASE, 2'd1, 16'h0000);

      // Length above the maximum while a sequence is still open; all-A k-mers
      // of different lengths land on the same counter.
      drain_and_settle();
      write_length(lengths[1]);
      repeat (3) push_request(CMD_ADD_BASE, 2'd0, 16'h5555);
      push_request(CMD_END_SEQ, 2'd2, 16'hAAAA);
      repeat (8) push_request(CMD_ADD_BASE, 2'd0, 16'hAAAA);
      push_request(CMD_READ, 2'd2, 16'h0000);

      // Random phases, each with its own length, one of them without idling.
      per_phase = RANDOM_BEATS / (12 - 1);
      for (int p = 1; p < 12; p++) begin
         if (p > 1) begin
            drain_and_settle();
            write_length(lengths[p]);
         end
         quiet = (p == 4);
         n = 0;
         while (n < per_phase) begin
            push_random(counted);
            if (counted) n++;
         end
      end
      quiet = 1'b0;
      drain_and_settle();

      if (board.errors == 0) begin
         $display("kmer_count_both_strands test passed");
      end else begin
         $display("kmer_count_both_strands test failed");
      end
      $finish;
   end

   // Run limit, well past the table clearing pass and the slowest stream.
   initial begin
      #5000000;
      $display("kmer_count_both_strands test failed");
      $finish;
   end

endmodule
